/* sv/wdas_pkg.sv */
// Shared types, codes and reset values for the winch descent/ascent sequencer.
package wdas_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;
  localparam logic [1:0] KIND_LIMIT   = 2'd3;

  // Command and sensor characters
  localparam logic [7:0] CHAR_GO     = 8'h47;  // 'G'
  localparam logic [7:0] CHAR_STOP   = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_LOWER  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER  = 8'h42;  // 'B'

  // Throttle limits in microseconds
  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MAX = 11'd2000;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_NEAR_DISTANCE       = 3'd0;
  localparam logic [2:0] REG_ARRIVE_DISTANCE     = 3'd1;
  localparam logic [2:0] REG_DROP_WAIT_TICKS     = 3'd2;
  localparam logic [2:0] REG_PULSE_FREE_FALL     = 3'd3;
  localparam logic [2:0] REG_PULSE_DESCENT_BRAKE = 3'd4;
  localparam logic [2:0] REG_PULSE_LIFT_FAST     = 3'd5;
  localparam logic [2:0] REG_PULSE_ASCENT_BRAKE  = 3'd6;
  localparam logic [2:0] REG_PULSE_NEUTRAL       = 3'd7;

  // Configuration reset values
  localparam logic [15:0] RST_NEAR_DISTANCE       = 16'd4000;
  localparam logic [15:0] RST_ARRIVE_DISTANCE     = 16'd500;
  localparam logic [15:0] RST_DROP_WAIT_TICKS     = 16'd2000;
  localparam logic [10:0] RST_PULSE_FREE_FALL     = 11'd1400;
  localparam logic [10:0] RST_PULSE_DESCENT_BRAKE = 11'd1450;
  localparam logic [10:0] RST_PULSE_LIFT_FAST     = 11'd1650;
  localparam logic [10:0] RST_PULSE_ASCENT_BRAKE  = 11'd1600;
  localparam logic [10:0] RST_PULSE_NEUTRAL       = 11'd1500;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_IDLE          = 3'd0,
    MODE_FREE_FALL     = 3'd1,
    MODE_DESCENT_BRAKE = 3'd2,
    MODE_PAYLOAD_DROP  = 3'd3,
    MODE_LIFT          = 3'd4,
    MODE_ASCENT_BRAKE  = 3'd5,
    MODE_HOLD          = 3'd6
  } mode_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  command_byte;
    logic [7:0]  sensor_id;
    logic [15:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [10:0] throttle_us;
  } out_item_t;

  typedef struct packed {
    logic [15:0] near_distance;
    logic [15:0] arrive_distance;
    logic [15:0] drop_wait_ticks;
    logic [10:0] pulse_free_fall;
    logic [10:0] pulse_descent_brake;
    logic [10:0] pulse_lift_fast;
    logic [10:0] pulse_ascent_brake;
    logic [10:0] pulse_neutral;
  } cfg_regs_t;

  // Limit a pulse width to the legal throttle range
  function automatic logic [10:0] clamp_pulse(input logic [10:0] us);
    logic [10:0] res;
    if (us < PULSE_MIN) begin
      res = PULSE_MIN;
    end else if (us > PULSE_MAX) begin
      res = PULSE_MAX;
    end else begin
      res = us;
    end
    return res;
  endfunction

endpackage

/* sv/wdas_cfg.sv */
// Configuration register file for the sequencer.
module wdas_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output wdas_pkg::cfg_regs_t regs
);
  import wdas_pkg::*;

  cfg_regs_t regs_r;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.near_distance       <= RST_NEAR_DISTANCE;
      regs_r.arrive_distance     <= RST_ARRIVE_DISTANCE;
      regs_r.drop_wait_ticks     <= RST_DROP_WAIT_TICKS;
      regs_r.pulse_free_fall     <= RST_PULSE_FREE_FALL;
      regs_r.pulse_descent_brake <= RST_PULSE_DESCENT_BRAKE;
      regs_r.pulse_lift_fast     <= RST_PULSE_LIFT_FAST;
      regs_r.pulse_ascent_brake  <= RST_PULSE_ASCENT_BRAKE;
      regs_r.pulse_neutral       <= RST_PULSE_NEUTRAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEAR_DISTANCE:       regs_r.near_distance       <= cfg_wdata;
        REG_ARRIVE_DISTANCE:     regs_r.arrive_distance     <= cfg_wdata;
        REG_DROP_WAIT_TICKS:     regs_r.drop_wait_ticks     <= cfg_wdata;
        REG_PULSE_FREE_FALL:     regs_r.pulse_free_fall     <= cfg_wdata[10:0];
        REG_PULSE_DESCENT_BRAKE: regs_r.pulse_descent_brake <= cfg_wdata[10:0];
        REG_PULSE_LIFT_FAST:     regs_r.pulse_lift_fast     <= cfg_wdata[10:0];
        REG_PULSE_ASCENT_BRAKE:  regs_r.pulse_ascent_brake  <= cfg_wdata[10:0];
        REG_PULSE_NEUTRAL:       regs_r.pulse_neutral       <= cfg_wdata[10:0];
        default:                 regs_r.pulse_neutral       <= regs_r.pulse_neutral;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

/* sv/wdas_core.sv */
// Mode, throttle and drop-wait state with the per-item update logic.
module wdas_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  wdas_pkg::in_item_t   item,
  input  wdas_pkg::cfg_regs_t  regs,
  output wdas_pkg::out_item_t  result
);
  import wdas_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [10:0] throttle_r, throttle_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;
  logic        lower_hit, upper_hit;

  assign lower_hit = (item.sensor_id == CHAR_LOWER);
  assign upper_hit = (item.sensor_id == CHAR_UPPER);
  assign count_inc = (count_r < COUNT_MAX) ? count_r + 16'd1 : count_r;

  // Work out the next mode from the item kind
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    unique case (item.cmd)
      KIND_TICK: begin
        if (mode_r == MODE_PAYLOAD_DROP) begin
          count_nxt = count_inc;
          if (count_inc >= regs.drop_wait_ticks) begin
            mode_nxt = MODE_LIFT;
          end
        end
      end
      KIND_COMMAND: begin
        if (item.command_byte == CHAR_GO) begin
          mode_nxt = MODE_FREE_FALL;
        end else if (item.command_byte == CHAR_STOP) begin
          mode_nxt = MODE_HOLD;
        end
      end
      KIND_FRAME: begin
        unique case (mode_r)
          MODE_FREE_FALL: begin
            if (lower_hit && item.distance < regs.near_distance) begin
              mode_nxt = MODE_DESCENT_BRAKE;
            end
          end
          MODE_DESCENT_BRAKE: begin
            if (lower_hit && item.distance < regs.arrive_distance) begin
              mode_nxt = MODE_PAYLOAD_DROP;
            end
          end
          MODE_LIFT: begin
            if (upper_hit && item.distance < regs.near_distance) begin
              mode_nxt = MODE_ASCENT_BRAKE;
            end
          end
          MODE_ASCENT_BRAKE: begin
            if (upper_hit && item.distance < regs.arrive_distance) begin
              mode_nxt = MODE_HOLD;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
      default: mode_nxt = MODE_HOLD;
    endcase
    // Drop the wait count on any mode change
    if (mode_nxt != mode_r) begin
      count_nxt = '0;
    end
  end

  // Throttle follows the new mode; payload drop keeps the old value
  always_comb begin
    unique case (mode_nxt)
      MODE_FREE_FALL:     throttle_nxt = clamp_pulse(regs.pulse_free_fall);
      MODE_DESCENT_BRAKE: throttle_nxt = clamp_pulse(regs.pulse_descent_brake);
      MODE_PAYLOAD_DROP:  throttle_nxt = throttle_r;
      MODE_LIFT:          throttle_nxt = clamp_pulse(regs.pulse_lift_fast);
      MODE_ASCENT_BRAKE:  throttle_nxt = clamp_pulse(regs.pulse_ascent_brake);
      default:            throttle_nxt = clamp_pulse(regs.pulse_neutral);
    endcase
  end

  // Advance state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      throttle_r <= RST_PULSE_NEUTRAL;
      count_r    <= '0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      throttle_r <= throttle_nxt;
      count_r    <= count_nxt;
    end
  end

  assign result.mode        = mode_nxt;
  assign result.throttle_us = throttle_nxt;

endmodule

/* sv/wdas_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
module wdas_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wdas_pkg::out_item_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output wdas_pkg::out_item_t out_data
);
  import wdas_pkg::*;

  logic      head_valid_r, skid_valid_r;
  out_item_t head_r, skid_r;
  logic      head_free;

  assign head_free = !head_valid_r || out_ready;

  // Refill the head from the skid first, then from the new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves with the valid bits
  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= push_data;
        end
      end else if (push) begin
        head_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

endmodule

/* sv/winch_descent_ascent_sequencer.sv */
// Top level of the winch descent/ascent mode sequencer.
//
// Usage:
//   Items arrive on the in_ channel (valid/ready): ticks, command bytes,
//   sensor distance frames and limit-switch events. Every transfer yields
//   exactly one result on the out_ channel: the mode and the throttle pulse
//   width in microseconds after that item.
//   The configuration port writes one of eight registers per cycle with
//   cfg_we high; write only while no results are outstanding.
// Timing:
//   The mode update is computed from the transferred item and the stored
//   state, and the result is registered into the output buffer at the transfer edge.
//   Throughput is one item per cycle while the output buffer has room.
//   A stalled receiver is absorbed by a two-entry output buffer (output
//   register plus skid register); in_ready drops only when both are full.
// Reset:
//   rst_n low for one clock returns to idle mode, throttle 1500 us, drop
//   wait count zero, configuration to defaults and empties the buffer.
module winch_descent_ascent_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wdas_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wdas_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import wdas_pkg::*;

  cfg_regs_t regs;
  out_item_t result;
  logic      in_xfer;

  assign in_xfer = in_valid && in_ready;

  wdas_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  wdas_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .item    (in_data),
    .regs    (regs),
    .result  (result)
  );

  wdas_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Backpressure only when a result is already waiting
  a_ready_implies_pending: assert property (
    @(posedge clk) disable iff (!rst_n) !in_ready |-> out_valid
  ) else $error("input stalled with no result pending");

  // Results always carry a throttle inside the legal range
  a_throttle_range: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_data.throttle_us >= PULSE_MIN &&
                     out_data.throttle_us <= PULSE_MAX)
  ) else $error("throttle out of range");

  // An input transfer always leaves a valid result at the output next cycle
  a_xfer_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n) in_xfer |=> out_valid
  ) else $error("transfer produced no result");

  // Buffer is empty right after reset
  a_empty_after_reset: assert property (
    @(posedge clk) $past(!rst_n) |-> !out_valid
  ) else $error("result valid right after reset");

endmodule
